/* src/perfect_in_shuffle_buffer_defines.svh */
// Assertion macros for the perfect in-shuffle buffer
`ifndef PERFECT_IN_SHUFFLE_BUFFER_DEFINES_SVH
`define PERFECT_IN_SHUFFLE_BUFFER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define PISB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pisb assertion failed");

// Next-cycle implication, disabled during reset
`define PISB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pisb assertion failed");

`endif

/* src/pisb_pkg.sv */
// Package: shared constants and types of the perfect in-shuffle buffer
`default_nettype none
package pisb_pkg;

    localparam int HALF_MAX  = 512;
    localparam int DEPTH     = 2 * HALF_MAX;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int POS_W     = ADDR_W + 1;
    localparam int CFG_W     = 10;
    localparam int WORD_BITS = 32;

    // request action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic read;
    } t_cmd;

endpackage
`default_nettype wire

/* src/pisb_in_if.sv */
// Interfaces: request channel and result channel
`default_nettype none
interface pisb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic signed [pisb_pkg::WORD_BITS-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface pisb_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [pisb_pkg::WORD_BITS-1:0] value_out;
    logic                                  last;
    logic                                  status;

    modport source (output valid, output value_out, output last, output status, input ready);
    modport sink   (input valid, input value_out, input last, input status, output ready);
endinterface
`default_nettype wire

/* src/perfect_in_shuffle_buffer.sv */
// Perfect in-shuffle permutation buffer: top level
// Usage:
//   Requests arrive on i_in (valid/ready). action ACT_LOAD stores the next word
//   of a set of 2n words, n being the half_length register; ACT_READ returns
//   the next word in perfect in-shuffle order on o_out (valid/ready).
//   A load produces no result. A read's result is presented the cycle after
//   the read is taken, once the registered read of the word store has
//   completed, and stays until the receiver takes it. The next request is
//   accepted in the cycle after the result is taken.
//   A read before the set is fully loaded returns value_out zero, status 1.
//   last marks the read of position 2n; the set is then empty again.
//   A load after a complete set starts a new set.
//   i_cfg_we writes half_length and empties the current set; write it only
//   while no request is outstanding.
//   Reset (i_rst_n low, synchronous) sets half_length to one and empties the
//   set; the word store is not cleared and needs no clearing pass.
//   While the receiver stalls, the result holds and no request is accepted.
`default_nettype none
`include "perfect_in_shuffle_buffer_defines.svh"
module perfect_in_shuffle_buffer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    pisb_in_if.sink                           i_in,
    pisb_out_if.source                        o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [pisb_pkg::CFG_W-1:0]   i_cfg_wdata
);

    pisb_pkg::t_cmd cmd;

    pisb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    pisb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in.value),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_value_out (o_out.value_out),
        .o_last      (o_out.last),
        .o_status    (o_out.status)
    );

    // one request at a time: never ready while a result is pending
    `PISB_ASSERT_NOW(a_one_outstanding, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    // an accepted read yields a result in the next cycle
    `PISB_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, cmd.read, o_out.valid)
    // an accepted load yields no result
    `PISB_ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, cmd.load, !o_out.valid)
    // the last word of a set is never a not-ready result
    `PISB_ASSERT_NOW(a_last_ok, i_clk, i_rst_n, o_out.valid && o_out.last, !o_out.status)

endmodule
`default_nettype wire

/* src/pisb_ctrl.sv */
// Controller: handshake state machine issuing load and read commands
`default_nettype none
module pisb_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_in_action,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output pisb_pkg::t_cmd       o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = (r_state == ST_RESP);
    assign accept      = i_in_valid && o_in_ready;

    // commands to the datapath
    always_comb begin
        o_cmd.load = accept && (i_in_action == pisb_pkg::ACT_LOAD);
        o_cmd.read = accept && (i_in_action == pisb_pkg::ACT_READ);
    end

    // next state: a read holds a result until it is taken
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.read) n_state = ST_RESP;
            end
            ST_RESP: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

/* src/pisb_datapath.sv */
// Datapath: length register, position counters, word store and result registers
`default_nettype none
module pisb_datapath (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire pisb_pkg::t_cmd                        i_cmd,
    input  wire logic signed [pisb_pkg::WORD_BITS-1:0] i_value,
    input  wire logic                                  i_cfg_we,
    input  wire logic [pisb_pkg::CFG_W-1:0]            i_cfg_wdata,
    output logic signed [pisb_pkg::WORD_BITS-1:0]      o_value_out,
    output logic                                       o_last,
    output logic                                       o_status
);

    localparam int POS_W  = pisb_pkg::POS_W;
    localparam int ADDR_W = pisb_pkg::ADDR_W;

    logic [pisb_pkg::CFG_W-1:0]     r_half;
    logic [POS_W-1:0]               r_count;
    logic [POS_W-1:0]               r_wr_pos;
    logic [POS_W-1:0]               r_rd_pos;
    logic                           r_last;
    logic                           r_status;
    logic [pisb_pkg::WORD_BITS-1:0] r_rd_data;
    logic [pisb_pkg::WORD_BITS-1:0] r_mem [pisb_pkg::DEPTH];

    logic [POS_W-1:0] half_eff;
    logic [POS_W-1:0] total;
    logic [POS_W-1:0] modulus;
    logic             set_full;
    logic [POS_W-1:0] wr_base;
    logic [POS_W-1:0] cnt_base;
    logic [POS_W:0]   wp_sum;
    logic [POS_W-1:0] wp_next;
    logic [POS_W-1:0] wr_addr;
    logic [POS_W-1:0] rp_next;

    // effective half length: zero reads as one, saturate at HALF_MAX, half the store size
    always_comb begin
        priority if (r_half == '0) begin
            half_eff = POS_W'(1);
        end else if (POS_W'(r_half) > POS_W'(pisb_pkg::HALF_MAX)) begin
            half_eff = POS_W'(pisb_pkg::HALF_MAX);
        end else begin
            half_eff = POS_W'(r_half);
        end
    end

    assign total    = half_eff << 1;
    assign modulus  = total + POS_W'(1);
    assign set_full = (r_count >= total);

    // a load after a full set starts a fresh one
    assign wr_base  = set_full ? '0 : r_wr_pos;
    assign cnt_base = set_full ? '0 : r_count;

    // write position steps by two modulo 2n+1
    assign wp_sum  = {1'b0, wr_base} + (POS_W + 1)'(2);
    assign wp_next = (wp_sum >= {1'b0, modulus}) ? POS_W'(wp_sum - {1'b0, modulus})
                                                 : POS_W'(wp_sum);
    assign wr_addr = wp_next - POS_W'(1);
    assign rp_next = r_rd_pos + POS_W'(1);

    // control state: length register and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half   <= pisb_pkg::CFG_W'(1);
            r_count  <= '0;
            r_wr_pos <= '0;
            r_rd_pos <= '0;
            r_last   <= 1'b0;
            r_status <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_half   <= i_cfg_wdata;
                r_count  <= '0;
                r_wr_pos <= '0;
                r_rd_pos <= '0;
            end else if (i_cmd.load) begin
                r_count  <= cnt_base + POS_W'(1);
                r_wr_pos <= wp_next;
                if (set_full) r_rd_pos <= '0;
            end else if (i_cmd.read) begin
                r_status <= !set_full;
                r_last   <= set_full && (rp_next >= total);
                if (set_full) begin
                    if (rp_next >= total) begin
                        r_count  <= '0;
                        r_wr_pos <= '0;
                        r_rd_pos <= '0;
                    end else begin
                        r_rd_pos <= rp_next;
                    end
                end
            end
        end
    end

    // word store: one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem[wr_addr[ADDR_W-1:0]] <= i_value;
        end
        if (i_cmd.read && set_full) begin
            r_rd_data <= r_mem[r_rd_pos[ADDR_W-1:0]];
        end
    end

    // a read before the set is complete returns zero
    assign o_value_out = r_status ? '0 : r_rd_data;
    assign o_last      = r_last;
    assign o_status    = r_status;

endmodule
`default_nettype wire

/* test/perfect_in_shuffle_buffer_tb.sv */
// Testbench for the perfect in-shuffle buffer: directed and random requests, scoreboard check
`timescale 1ns / 1ps
module perfect_in_shuffle_buffer_tb;

    localparam int DRAIN_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_ITEMS   = 200;
    localparam int HOLD_CYCLES   = 300;

    // one shuffled word as it leaves the block
    typedef struct {
        logic signed [pisb_pkg::WORD_BITS-1:0] value_out;
        logic                                  last;
        logic                                  status;
    } t_shuffle_word;

    // predictor of the shuffle buffer plus the queue of words still to come out
    class shuffle_scoreboard;
        logic [pisb_pkg::WORD_BITS-1:0] word_store [pisb_pkg::DEPTH];
        logic [pisb_pkg::CFG_W-1:0]     half_reg;
        int unsigned                    loaded_words;
        int unsigned                    wr_pos;
        int unsigned                    rd_pos;
        t_shuffle_word                  expected_words [$];
        int unsigned                    errors;
        int unsigned                    loads_seen;
        int unsigned                    reads_seen;
        int unsigned                    early_reads;
        int unsigned                    sets_read;
        int unsigned                    lengths_written;
        int unsigned                    widest_half;

        function new();
            half_reg        = 1;
            errors          = 0;
            loads_seen      = 0;
            reads_seen      = 0;
            early_reads     = 0;
            sets_read       = 0;
            lengths_written = 0;
            widest_half     = 1;
            clear_set();
        endfunction

        function void clear_set();
            loaded_words = 0;
            wr_pos       = 0;
            rd_pos       = 0;
        endfunction

        // zero acts as one, anything above HALF_MAX (half the store size) saturates
        function int unsigned effective_half();
            if (half_reg == 0)
                return 1;
            if (half_reg > pisb_pkg::HALF_MAX)
                return pisb_pkg::HALF_MAX;
            return half_reg;
        endfunction

        function int unsigned requests_seen();
            return loads_seen + reads_seen;
        endfunction

        function void set_length(logic [pisb_pkg::CFG_W-1:0] len);
            half_reg = len;
            clear_set();
            lengths_written++;
            if (effective_half() > widest_half)
                widest_half = effective_half();
        endfunction

        // apply one accepted request and queue the word it produces, if any
        function void note_request(logic act, logic [pisb_pkg::WORD_BITS-1:0] val);
            int unsigned   words;
            t_shuffle_word word;
            words = 2 * effective_half();
            if (act == pisb_pkg::ACT_LOAD) begin
                loads_seen++;
                if (loaded_words >= words)
                    clear_set();
                wr_pos += 2;
                if (wr_pos >= words + 1)
                    wr_pos -= words + 1;
                if (wr_pos >= 1 && wr_pos <= words)
                    word_store[wr_pos - 1] = val;
                loaded_words++;
            end else begin
                reads_seen++;
                if (loaded_words < words) begin
                    word.value_out = '0;
                    word.last      = 1'b0;
                    word.status    = 1'b1;
                    early_reads++;
                end else begin
                    rd_pos++;
                    word.value_out = word_store[rd_pos - 1];
                    word.status    = 1'b0;
                    word.last      = (rd_pos >= words);
                    if (word.last) begin
                        sets_read++;
                        clear_set();
                    end
                end
                expected_words.push_back(word);
            end
        endfunction

        // compare one accepted word with the oldest prediction
        function void check_result(logic [pisb_pkg::WORD_BITS-1:0] value_out,
                                   logic last, logic status);
            t_shuffle_word want;
            if (expected_words.size() == 0) begin
                $error("unexpected word: value_out %0d last %0b status %0b",
                       $signed(value_out), last, status);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (value_out !== want.value_out) begin
                $error("value_out: expected %0d, actual %0d", want.value_out, $signed(value_out));
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0b, actual %0b", want.last, last);
                errors++;
            end
            if (status !== want.status) begin
                $error("status: expected %0b, actual %0b", want.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [pisb_pkg::CFG_W-1:0] i_cfg_wdata;

    pisb_in_if  req_if ();
    pisb_out_if res_if ();

    shuffle_scoreboard board;
    int unsigned       tx_idle_pct;
    int unsigned       rx_idle_pct;
    int unsigned       hold_left;

    perfect_in_shuffle_buffer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_if),
        .o_out       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("run timed out");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver: check taken words, randomise ready, honour long hold-offs
    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid === 1'b1 && res_if.ready)
                board.check_result(res_if.value_out, res_if.last, res_if.status);
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else begin
                res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one request, with a random gap first, and wait for it to be taken
    task automatic send_request(input logic act, input logic [pisb_pkg::WORD_BITS-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.action <= act;
        req_if.value  <= val;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        board.note_request(act, val);
    endtask

    task automatic load_words(input int unsigned count);
        repeat (count) send_request(pisb_pkg::ACT_LOAD, $urandom);
    endtask

    task automatic read_words(input int unsigned count);
        repeat (count) send_request(pisb_pkg::ACT_READ, $urandom);
    endtask

    // stop offering, wait for every predicted word, then let the block settle
    task automatic wait_results_drained();
        int waited;
        req_if.valid <= 1'b0;
        waited = 0;
        while (board.expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (board.expected_words.size() != 0) begin
            $error("%0d expected words never arrived", board.expected_words.size());
            board.errors++;
            board.expected_words.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // half_length write; only called with the block idle
    task automatic write_length(input logic [pisb_pkg::CFG_W-1:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        board.set_length(len);
        i_cfg_we    <= 1'b0;
    endtask

    // random rounds: a length setting, then mostly whole sets, some broken ones and noise
    task automatic run_random_phase(input int unsigned budget);
        int unsigned stop_at;
        int unsigned words;
        int unsigned pick;
        int unsigned part;
        stop_at = board.requests_seen() + budget;
        while (board.requests_seen() < stop_at) begin
            wait_results_drained();
            pick = $urandom_range(99);
            if (pick < 70)
                write_length(pisb_pkg::CFG_W'($urandom_range(8, 1)));
            else if (pick < 80)
                write_length('0);
            else if (pick < 90)
                write_length(pisb_pkg::CFG_W'($urandom_range(40, 9)));
            else
                write_length(pisb_pkg::CFG_W'($urandom_range(1023)));
            words = 2 * board.effective_half();
            if (words > 80) begin
                // too long to fill here: loads and early reads only
                repeat (20) send_request(1'($urandom_range(1)), $urandom);
            end else begin
                repeat ($urandom_range(6, 3)) begin
                    if (board.requests_seen() >= stop_at)
                        break;
                    pick = $urandom_range(99);
                    if (pick < 60) begin
                        load_words(words);
                        read_words(words);
                    end else if (pick < 72) begin
                        // read while the set is still short
                        part = $urandom_range(words - 1, 0);
                        load_words(part);
                        send_request(pisb_pkg::ACT_READ, $urandom);
                        load_words(words - part);
                        read_words(words);
                    end else if (pick < 82) begin
                        // readout cut short; the next load starts a new set
                        load_words(words);
                        read_words($urandom_range(words - 1, 0));
                    end else if (pick < 90) begin
                        // reads past the end of the set
                        load_words(words);
                        read_words(words + $urandom_range(3, 1));
                    end else begin
                        repeat (10) send_request(1'($urandom_range(1)), $urandom);
                    end
                    if ($urandom_range(9) == 0)
                        wait_results_drained();
                end
            end
        end
    endtask

    // main sequence
    initial begin
        board         = new();
        tx_idle_pct   = 0;
        rx_idle_pct   = 0;
        hold_left     = 0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        req_if.valid  <= 1'b0;
        req_if.action <= pisb_pkg::ACT_LOAD;
        req_if.value  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length of one: read of an empty set, early read, full readout
        send_request(pisb_pkg::ACT_READ, '0);
        send_request(pisb_pkg::ACT_LOAD, 32'h7FFF_FFFF);
        send_request(pisb_pkg::ACT_READ, 32'hFFFF_FFFF);
        send_request(pisb_pkg::ACT_LOAD, 32'h8000_0000);
        send_request(pisb_pkg::ACT_READ, '0);
        send_request(pisb_pkg::ACT_READ, '0);
        send_request(pisb_pkg::ACT_READ, '0);
        // loads after a complete set, before and during its readout
        send_request(pisb_pkg::ACT_LOAD, 32'hFFFF_FFFF);
        send_request(pisb_pkg::ACT_LOAD, 32'h0000_0000);
        send_request(pisb_pkg::ACT_LOAD, 32'h5555_5555);
        send_request(pisb_pkg::ACT_LOAD, 32'hAAAA_AAAA);
        send_request(pisb_pkg::ACT_READ, '0);
        send_request(pisb_pkg::ACT_LOAD, 32'h1234_5678);
        send_request(pisb_pkg::ACT_LOAD, 32'h9ABC_DEF0);
        send_request(pisb_pkg::ACT_READ, '0);
        send_request(pisb_pkg::ACT_READ, '0);

        // zero length behaves as one
        wait_results_drained();
        write_length('0);
        load_words(2);
        read_words(2);

        // full length, partly loaded, then emptied by the next write
        wait_results_drained();
        write_length(pisb_pkg::CFG_W'(pisb_pkg::HALF_MAX));
        load_words(3);
        send_request(pisb_pkg::ACT_READ, '0);

        // all ones saturates to the largest set; the first reads show the wrap
        wait_results_drained();
        write_length('1);
        load_words(2 * pisb_pkg::HALF_MAX);
        read_words(2);

        // receiver holds off while requests keep coming
        wait_results_drained();
        write_length(pisb_pkg::CFG_W'(4));
        hold_left = HOLD_CYCLES;
        repeat (2) begin
            load_words(8);
            read_words(8);
        end

        tx_idle_pct = 10;
        rx_idle_pct = 81;
        run_random_phase(PHASE_ITEMS);
        tx_idle_pct = 81;
        rx_idle_pct = 10;
        run_random_phase(PHASE_ITEMS);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(PHASE_ITEMS);

        wait_results_drained();
        $display("Covered %0d loads and %0d reads, %0d of the reads on an unfinished set.",
                 board.loads_seen, board.reads_seen, board.early_reads);
        $display("%0d sets read out over %0d length writes, half-length up to %0d.",
                 board.sets_read, board.lengths_written, board.widest_half);
        if (board.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
